FILE: rtl/dtl_pkg.sv
// Shared types, constants and helper functions of the token lexer.
package dtl_pkg;

   // Text size limit and the resulting offset saturation point
   localparam longint unsigned MAX_TEXT_BYTES = 64'd65536;
   localparam logic [15:0] OFF_CAP = (MAX_TEXT_BYTES - 64'd1 > 64'd65535) ? 16'hFFFF
                                     : 16'(MAX_TEXT_BYTES - 64'd1);
   localparam logic [15:0] LINE_CAP = 16'hFFFF;
   localparam logic [15:0] FIRST_LINE_RESET = 16'd1;

   // Group queue depth
   localparam int QUEUE_DEPTH = 2;

   // Characters
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_T       = 8'h74;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_EQ      = 8'h3D;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_NL      = 8'h0A;
   localparam logic [7:0] CH_NUL     = 8'h00;

   // Token kinds
   localparam logic [4:0] K_EOF      = 5'd0;
   localparam logic [4:0] K_LBRACE   = 5'd1;
   localparam logic [4:0] K_RBRACE   = 5'd2;
   localparam logic [4:0] K_LPAREN   = 5'd3;
   localparam logic [4:0] K_RPAREN   = 5'd4;
   localparam logic [4:0] K_LBRACK   = 5'd5;
   localparam logic [4:0] K_RBRACK   = 5'd6;
   localparam logic [4:0] K_COLON    = 5'd7;
   localparam logic [4:0] K_SEMI     = 5'd8;
   localparam logic [4:0] K_COMMA    = 5'd9;
   localparam logic [4:0] K_DOT      = 5'd10;
   localparam logic [4:0] K_DOTDOT   = 5'd11;
   localparam logic [4:0] K_PLUS     = 5'd12;
   localparam logic [4:0] K_MINUS    = 5'd13;
   localparam logic [4:0] K_STAR     = 5'd14;
   localparam logic [4:0] K_SLASH    = 5'd15;
   localparam logic [4:0] K_ASSIGN   = 5'd16;
   localparam logic [4:0] K_EQ       = 5'd17;
   localparam logic [4:0] K_NEQ      = 5'd18;
   localparam logic [4:0] K_LT       = 5'd19;
   localparam logic [4:0] K_LTE      = 5'd20;
   localparam logic [4:0] K_GT       = 5'd21;
   localparam logic [4:0] K_GTE      = 5'd22;
   localparam logic [4:0] K_STRING   = 5'd23;
   localparam logic [4:0] K_NUMBER   = 5'd24;
   localparam logic [4:0] K_PERCENT  = 5'd25;
   localparam logic [4:0] K_DURATION = 5'd26;
   localparam logic [4:0] K_IDENT    = 5'd27;

   // Error codes
   localparam logic [2:0] E_NONE     = 3'd0;
   localparam logic [2:0] E_BLOCK    = 3'd1;
   localparam logic [2:0] E_STRING   = 3'd2;
   localparam logic [2:0] E_ESCAPE   = 3'd3;
   localparam logic [2:0] E_BANG     = 3'd4;
   localparam logic [2:0] E_BADCHAR  = 3'd5;

   // Lexer modes
   typedef enum logic [3:0] {
      M_IDLE, M_SLASH, M_LINE, M_BLOCK, M_BSTAR, M_DOT, M_EQ, M_BANG, M_LT,
      M_GT, M_STR, M_ESC, M_INT, M_NDOT, M_FRAC, M_IDENT
   } mode_type;

   // One result item
   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] start;
      logic [15:0] len;
      logic [15:0] line;
      logic [2:0]  err;
   } res_type;

   // All results caused by one input item
   typedef struct packed {
      res_type [2:0] r;
      logic [1:0]    cnt;
   } group_type;

   function automatic res_type mk_res(input logic [4:0] kind, input logic [15:0] start,
                                      input logic [15:0] len, input logic [15:0] line,
                                      input logic [2:0] err);
      res_type r;
      r.kind  = kind;
      r.start = start;
      r.len   = len;
      r.line  = line;
      r.err   = err;
      return r;
   endfunction

   function automatic logic [15:0] span(input logic [15:0] from, input logic [15:0] to);
      return (to > from) ? to - from : 16'd0;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
   endfunction

   function automatic logic [4:0] single_kind(input logic [7:0] c);
      logic [4:0] k;
      case (c)
         8'h7B:   k = K_LBRACE;
         8'h7D:   k = K_RBRACE;
         8'h28:   k = K_LPAREN;
         8'h29:   k = K_RPAREN;
         8'h5B:   k = K_LBRACK;
         8'h5D:   k = K_RBRACK;
         8'h3A:   k = K_COLON;
         8'h3B:   k = K_SEMI;
         8'h2C:   k = K_COMMA;
         8'h2B:   k = K_PLUS;
         8'h2D:   k = K_MINUS;
         8'h2A:   k = K_STAR;
         default: k = K_EOF;
      endcase
      return k;
   endfunction

endpackage

FILE: rtl/dtl_front.sv
// Front end: takes one byte per item, runs the lexer state machine, builds result groups.
module dtl_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [7:0]         req_ch,
   input  logic               req_end_of_text,
   input  logic               accept,
   input  logic               csr_we,
   input  logic [15:0]        csr_data,
   output logic               push,
   output dtl_pkg::group_type push_grp
);
   import dtl_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [15:0] tb_ff, tb_in;
   logic [15:0] off_ff, off_in;
   logic [15:0] line_ff, line_in;
   logic [15:0] ssl_ff, ssl_in;
   logic [15:0] dot_ff, dot_in;
   logic        halted_ff, halted_in;
   logic        in_text_ff, in_text_in;
   logic [15:0] first_line_ff;

   logic          is_end;
   logic          redo;
   logic          e_v;
   logic [4:0]    ek;
   logic [15:0]   es, el;
   logic [2:0]    ee;
   logic [1:0]    cnt_v;
   res_type [2:0] res_v;
   logic [4:0]    two_k, one_k;

   assign is_end = req_end_of_text || (req_ch == CH_NUL);

   // Lexer step for one item, up to three passes over the byte
   always_comb begin
      mode_in    = mode_ff;
      tb_in      = tb_ff;
      off_in     = off_ff;
      line_in    = line_ff;
      ssl_in     = ssl_ff;
      dot_in     = dot_ff;
      halted_in  = halted_ff;
      in_text_in = in_text_ff;
      cnt_v      = 2'd0;
      res_v      = '0;
      redo       = 1'b0;
      e_v        = 1'b0;
      ek         = K_EOF;
      es         = 16'd0;
      el         = 16'd0;
      ee         = E_NONE;
      two_k      = K_EQ;
      one_k      = K_ASSIGN;
      if (is_end) begin
         // flush the pending token
         if (!halted_ff) begin
            case (mode_ff)
               M_SLASH: begin
                  res_v[0] = mk_res(K_SLASH, tb_ff, 16'd1, line_ff, E_NONE);
                  cnt_v = 2'd1;
               end
               M_BLOCK, M_BSTAR: begin
                  res_v[0] = mk_res(K_EOF, off_ff, 16'd0, line_ff, E_BLOCK);
                  cnt_v = 2'd1;
                  halted_in = 1'b1;
               end
               M_DOT: begin
                  res_v[0] = mk_res(K_DOT, tb_ff, 16'd1, line_ff, E_NONE);
                  cnt_v = 2'd1;
               end
               M_EQ: begin
                  res_v[0] = mk_res(K_ASSIGN, tb_ff, 16'd1, line_ff, E_NONE);
                  cnt_v = 2'd1;
               end
               M_LT: begin
                  res_v[0] = mk_res(K_LT, tb_ff, 16'd1, line_ff, E_NONE);
                  cnt_v = 2'd1;
               end
               M_GT: begin
                  res_v[0] = mk_res(K_GT, tb_ff, 16'd1, line_ff, E_NONE);
                  cnt_v = 2'd1;
               end
               M_BANG: begin
                  res_v[0] = mk_res(K_EOF, tb_ff, 16'd0, line_ff, E_BANG);
                  cnt_v = 2'd1;
                  halted_in = 1'b1;
               end
               M_STR: begin
                  res_v[0] = mk_res(K_EOF, tb_ff, 16'd0, ssl_ff, E_STRING);
                  cnt_v = 2'd1;
                  halted_in = 1'b1;
               end
               M_ESC: begin
                  res_v[0] = mk_res(K_EOF, tb_ff, 16'd0, ssl_ff, E_ESCAPE);
                  cnt_v = 2'd1;
                  halted_in = 1'b1;
               end
               M_INT, M_FRAC: begin
                  res_v[0] = mk_res(K_NUMBER, tb_ff, span(tb_ff, off_ff), line_ff, E_NONE);
                  cnt_v = 2'd1;
               end
               M_NDOT: begin
                  res_v[0] = mk_res(K_NUMBER, tb_ff, span(tb_ff, dot_ff), line_ff, E_NONE);
                  res_v[1] = mk_res(K_DOT, dot_ff, 16'd1, line_ff, E_NONE);
                  cnt_v = 2'd2;
               end
               M_IDENT: begin
                  res_v[0] = mk_res(K_IDENT, tb_ff, span(tb_ff, off_ff), line_ff, E_NONE);
                  cnt_v = 2'd1;
               end
               default: ;
            endcase
            if (!halted_in) begin
               res_v[cnt_v] = mk_res(K_EOF, off_ff, 16'd0, line_ff, E_NONE);
               cnt_v = cnt_v + 2'd1;
            end
         end
         // fresh text
         mode_in    = M_IDLE;
         tb_in      = 16'd0;
         off_in     = 16'd0;
         line_in    = first_line_ff;
         ssl_in     = 16'd0;
         halted_in  = 1'b0;
         dot_in     = 16'd0;
         in_text_in = 1'b0;
      end else begin
         in_text_in = 1'b1;
         redo = !halted_ff;
         for (int p = 0; p < 3; p++) begin
            if (redo && !halted_in) begin
               redo = 1'b0;
               e_v  = 1'b0;
               case (mode_in)
                  M_IDLE: begin
                     if (is_space(req_ch)) begin
                        e_v = 1'b0;
                     end else if (single_kind(req_ch) != K_EOF) begin
                        e_v = 1'b1; ek = single_kind(req_ch); es = off_ff; el = 16'd1;
                        ee = E_NONE;
                     end else begin
                        tb_in = off_ff;
                        if (req_ch == CH_HASH) mode_in = M_LINE;
                        else if (req_ch == CH_SLASH) mode_in = M_SLASH;
                        else if (req_ch == CH_DOT) mode_in = M_DOT;
                        else if (req_ch == CH_EQ) mode_in = M_EQ;
                        else if (req_ch == CH_BANG) mode_in = M_BANG;
                        else if (req_ch == CH_LT) mode_in = M_LT;
                        else if (req_ch == CH_GT) mode_in = M_GT;
                        else if (req_ch == CH_QUOTE) begin
                           tb_in   = (off_ff < OFF_CAP) ? off_ff + 16'd1 : OFF_CAP;
                           ssl_in  = line_ff;
                           mode_in = M_STR;
                        end else if (is_digit(req_ch)) mode_in = M_INT;
                        else if (is_alpha(req_ch)) mode_in = M_IDENT;
                        else begin
                           e_v = 1'b1; ek = K_EOF; es = off_ff; el = 16'd0; ee = E_BADCHAR;
                           halted_in = 1'b1;
                        end
                     end
                  end
                  M_SLASH: begin
                     if (req_ch == CH_SLASH) mode_in = M_LINE;
                     else if (req_ch == CH_STAR) mode_in = M_BLOCK;
                     else begin
                        e_v = 1'b1; ek = K_SLASH; es = tb_in; el = 16'd1; ee = E_NONE;
                        mode_in = M_IDLE; redo = 1'b1;
                     end
                  end
                  M_LINE: begin
                     if (req_ch == CH_NL) mode_in = M_IDLE;
                  end
                  M_BLOCK: begin
                     if (req_ch == CH_STAR) mode_in = M_BSTAR;
                  end
                  M_BSTAR: begin
                     if (req_ch == CH_SLASH) mode_in = M_IDLE;
                     else if (req_ch != CH_STAR) mode_in = M_BLOCK;
                  end
                  M_DOT: begin
                     mode_in = M_IDLE;
                     e_v = 1'b1; es = tb_in; ee = E_NONE;
                     if (req_ch == CH_DOT) begin
                        ek = K_DOTDOT; el = 16'd2;
                     end else begin
                        ek = K_DOT; el = 16'd1; redo = 1'b1;
                     end
                  end
                  M_EQ, M_LT, M_GT: begin
                     two_k = (mode_in == M_EQ) ? K_EQ : (mode_in == M_LT) ? K_LTE : K_GTE;
                     one_k = (mode_in == M_EQ) ? K_ASSIGN : (mode_in == M_LT) ? K_LT : K_GT;
                     mode_in = M_IDLE;
                     e_v = 1'b1; es = tb_in; ee = E_NONE;
                     if (req_ch == CH_EQ) begin
                        ek = two_k; el = 16'd2;
                     end else begin
                        ek = one_k; el = 16'd1; redo = 1'b1;
                     end
                  end
                  M_BANG: begin
                     mode_in = M_IDLE;
                     e_v = 1'b1; es = tb_in;
                     if (req_ch == CH_EQ) begin
                        ek = K_NEQ; el = 16'd2; ee = E_NONE;
                     end else begin
                        ek = K_EOF; el = 16'd0; ee = E_BANG; halted_in = 1'b1;
                     end
                  end
                  M_STR: begin
                     if (req_ch == CH_QUOTE) begin
                        e_v = 1'b1; ek = K_STRING; es = tb_in; el = span(tb_in, off_ff);
                        ee = E_NONE; mode_in = M_IDLE;
                     end else if (req_ch == CH_BSLASH) mode_in = M_ESC;
                  end
                  M_ESC: begin
                     mode_in = M_STR;
                  end
                  M_INT, M_FRAC: begin
                     if (is_digit(req_ch)) begin
                        e_v = 1'b0;
                     end else if (req_ch == CH_DOT && mode_in == M_INT) begin
                        dot_in = off_ff; mode_in = M_NDOT;
                     end else begin
                        mode_in = M_IDLE;
                        e_v = 1'b1; es = tb_in; el = span(tb_in, off_ff); ee = E_NONE;
                        if (req_ch == CH_PERCENT) ek = K_PERCENT;
                        else if (req_ch == CH_T) ek = K_DURATION;
                        else begin
                           ek = K_NUMBER; redo = 1'b1;
                        end
                     end
                  end
                  M_NDOT: begin
                     if (is_digit(req_ch)) mode_in = M_FRAC;
                     else begin
                        e_v = 1'b1; ek = K_NUMBER; es = tb_in; el = span(tb_in, dot_in);
                        ee = E_NONE;
                        tb_in = dot_in; mode_in = M_DOT; redo = 1'b1;
                     end
                  end
                  M_IDENT: begin
                     if (!(is_alpha(req_ch) || is_digit(req_ch))) begin
                        e_v = 1'b1; ek = K_IDENT; es = tb_in; el = span(tb_in, off_ff);
                        ee = E_NONE; mode_in = M_IDLE; redo = 1'b1;
                     end
                  end
                  default: begin
                     mode_in = M_IDLE; redo = 1'b1;
                  end
               endcase
               if (e_v) begin
                  res_v[cnt_v] = mk_res(ek, es, el, line_ff, ee);
                  cnt_v = cnt_v + 2'd1;
               end
            end
         end
         // position counters saturate
         if (!halted_ff) begin
            if (off_ff < OFF_CAP) off_in = off_ff + 16'd1;
            if (req_ch == CH_NL && line_ff < LINE_CAP) line_in = line_ff + 16'd1;
         end
      end
   end

   assign push         = accept && (cnt_v != 2'd0);
   assign push_grp.r   = res_v;
   assign push_grp.cnt = cnt_v;

   // Lexer state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= M_IDLE;
         tb_ff         <= 16'd0;
         off_ff        <= 16'd0;
         line_ff       <= FIRST_LINE_RESET;
         ssl_ff        <= 16'd0;
         dot_ff        <= 16'd0;
         halted_ff     <= 1'b0;
         in_text_ff    <= 1'b0;
         first_line_ff <= FIRST_LINE_RESET;
      end else begin
         if (accept && req_valid) begin
            mode_ff    <= mode_in;
            tb_ff      <= tb_in;
            off_ff     <= off_in;
            line_ff    <= line_in;
            ssl_ff     <= ssl_in;
            dot_ff     <= dot_in;
            halted_ff  <= halted_in;
            in_text_ff <= in_text_in;
         end
         // first_line write also moves the line count before any byte of a text
         if (csr_we) begin
            first_line_ff <= csr_data;
            if (!in_text_ff) line_ff <= csr_data;
         end
      end
   end

endmodule

FILE: rtl/dtl_queue.sv
// Short queue of result groups between the front and back ends.
module dtl_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dtl_pkg::group_type push_grp,
   input  logic               pop,
   output dtl_pkg::group_type head,
   output logic               nonempty,
   output logic               full
);
   import dtl_pkg::*;

   localparam int PtrW = $clog2(QUEUE_DEPTH);

   group_type             mem_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]       wr_ff, rd_ff;
   logic [PtrW:0]         count_ff;

   assign nonempty = count_ff != '0;
   assign full     = count_ff == (PtrW+1)'(QUEUE_DEPTH);
   assign head     = mem_ff[rd_ff];

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_grp;
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         if (pop)  rd_ff <= (rd_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

FILE: rtl/dtl_back.sv
// Back end: unpacks result groups into single items behind an output register.
module dtl_back (
   input  logic               clock,
   input  logic               reset,
   input  dtl_pkg::group_type head,
   input  logic               nonempty,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [4:0]         rsp_token_kind,
   output logic [15:0]        rsp_token_start,
   output logic [15:0]        rsp_token_len,
   output logic [15:0]        rsp_token_line,
   output logic [2:0]         rsp_error_code,
   output logic               rsp_last
);
   import dtl_pkg::*;

   logic        valid_ff;
   logic [1:0]  idx_ff;
   res_type     out_ff;
   logic        last_ff;
   logic        load;
   logic        is_last;

   assign load    = nonempty && (!valid_ff || !rsp_stall);
   assign is_last = (idx_ff == head.cnt - 2'd1);
   assign pop     = load && is_last;

   // Output register and position within the head group
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= is_last ? 2'd0 : idx_ff + 2'd1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff  <= head.r[idx_ff];
         last_ff <= is_last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_token_kind  = out_ff.kind;
   assign rsp_token_start = out_ff.start;
   assign rsp_token_len   = out_ff.len;
   assign rsp_token_line  = out_ff.line;
   assign rsp_error_code  = out_ff.err;
   assign rsp_last        = last_ff;

endmodule

FILE: rtl/dsl_token_lexer_top.sv
// Top level of the streaming token lexer: front end, group queue, back end.
//
//  channel  dir  handshake          payload
//  req      in   valid / stall      ch, end_of_text
//  rsp      out  valid / stall      token_kind, token_start, token_len, token_line,
//                                   error_code, last
//  csr      in   valid / ready      data (first_line)
//
// One byte is taken per cycle while the group queue has room; a byte that causes
// several results is spread out at the output, one result per cycle while rsp is
// not stalled, so the sustained rate is one byte per cycle unless the token stream
// outpaces one result per cycle. Results pass through the group queue and the
// output register. Reset is synchronous and clears all lexer state; first_line
// returns to 1. A stall on rsp fills the queue and then stalls req.
module dsl_token_lexer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_len,
   output logic [15:0] rsp_token_line,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   import dtl_pkg::*;

   logic      accept;
   logic      push, pop, nonempty, full;
   group_type push_grp, head;

   assign req_stall = full;
   assign accept    = req_valid && !full;
   assign csr_ready = 1'b1;

   dtl_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ch          (req_ch),
      .req_end_of_text (req_end_of_text),
      .accept          (accept),
      .csr_we          (csr_valid && csr_ready),
      .csr_data        (csr_data),
      .push            (push),
      .push_grp        (push_grp)
   );

   dtl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_grp (push_grp),
      .pop      (pop),
      .head     (head),
      .nonempty (nonempty),
      .full     (full)
   );

   dtl_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .nonempty        (nonempty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_token_start (rsp_token_start),
      .rsp_token_len   (rsp_token_len),
      .rsp_token_line  (rsp_token_line),
      .rsp_error_code  (rsp_error_code),
      .rsp_last        (rsp_last)
   );

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the streaming token lexer.
module tb;
   import dtl_pkg::*;

   localparam int LIMIT = 3000000;

   typedef struct {
      logic [7:0] ch;
      logic       eot;
   } byte_item_type;

   typedef struct {
      logic [4:0]  kind;
      logic [15:0] start;
      logic [15:0] len;
      logic [15:0] line;
      logic [2:0]  err;
      logic        last;
   } token_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [7:0]  req_ch = 0;
   logic        req_end_of_text = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [4:0]  rsp_token_kind;
   logic [15:0] rsp_token_start;
   logic [15:0] rsp_token_len;
   logic [15:0] rsp_token_line;
   logic [2:0]  rsp_error_code;
   logic        rsp_last;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [15:0] csr_data = 0;

   byte_item_type src_bytes[$];
   token_type     tokens_due[$];
   token_type     burst[$];
   int          idle_pct = 30;
   int          fails = 0;
   int          cycles = 0;
   int          pushed = 0;
   bit          req_acc = 0;

   // lexer shadow state
   mode_type    p_mode;
   logic [15:0] p_begin, p_off, p_line, p_sline, p_dot, p_first;
   bit          p_halt, p_intext;

   dsl_token_lexer_top dut (.*);

   always #4 clock = ~clock;

   // ---------------- predictor ----------------
   function automatic logic [15:0] gap(logic [15:0] from, logic [15:0] upto);
      return (upto > from) ? upto - from : 16'd0;
   endfunction

   function automatic void put(logic [4:0] k, logic [15:0] s, logic [15:0] l,
                               logic [15:0] ln, logic [2:0] e);
      token_type t;
      t = '{k, s, l, ln, e, 1'b0};
      if (burst.size() < 3) burst.push_back(t);
   endfunction

   function automatic void halt_with(logic [15:0] s, logic [15:0] ln, logic [2:0] e);
      put(K_EOF, s, 16'd0, ln, e);
      p_halt = 1;
   endfunction

   function automatic void text_restart();
      p_mode = M_IDLE; p_begin = 0; p_off = 0; p_line = p_first;
      p_sline = 0; p_halt = 0; p_dot = 0; p_intext = 0;
   endfunction

   function automatic bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic [4:0] punct_kind(logic [7:0] c);
      case (c)
         "{": return K_LBRACE;
         "}": return K_RBRACE;
         "(": return K_LPAREN;
         ")": return K_RPAREN;
         "[": return K_LBRACK;
         "]": return K_RBRACK;
         ":": return K_COLON;
         ";": return K_SEMI;
         ",": return K_COMMA;
         "+": return K_PLUS;
         "-": return K_MINUS;
         "*": return K_STAR;
         default: return K_EOF;
      endcase
   endfunction

   // one byte in the current mode; returns 1 when the byte must be seen again
   function automatic bit lex_byte(logic [7:0] c);
      logic [15:0] off, ln;
      logic [4:0]  k, two, one;
      off = p_off;
      ln = p_line;
      case (p_mode)
         M_IDLE: begin
            if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) return 0;
            k = punct_kind(c);
            if (k != K_EOF) begin
               put(k, off, 16'd1, ln, E_NONE);
               return 0;
            end
            p_begin = off;
            if (c == CH_HASH) p_mode = M_LINE;
            else if (c == CH_SLASH) p_mode = M_SLASH;
            else if (c == CH_DOT) p_mode = M_DOT;
            else if (c == CH_EQ) p_mode = M_EQ;
            else if (c == CH_BANG) p_mode = M_BANG;
            else if (c == CH_LT) p_mode = M_LT;
            else if (c == CH_GT) p_mode = M_GT;
            else if (c == CH_QUOTE) begin
               p_begin = (off < OFF_CAP) ? off + 16'd1 : OFF_CAP;
               p_sline = ln;
               p_mode = M_STR;
            end else if (digit(c)) p_mode = M_INT;
            else if (letter(c)) p_mode = M_IDENT;
            else halt_with(off, ln, E_BADCHAR);
            return 0;
         end
         M_SLASH: begin
            if (c == CH_SLASH) begin p_mode = M_LINE; return 0; end
            if (c == CH_STAR) begin p_mode = M_BLOCK; return 0; end
            put(K_SLASH, p_begin, 16'd1, ln, E_NONE);
            p_mode = M_IDLE;
            return 1;
         end
         M_LINE: begin
            if (c == CH_NL) p_mode = M_IDLE;
            return 0;
         end
         M_BLOCK: begin
            if (c == CH_STAR) p_mode = M_BSTAR;
            return 0;
         end
         M_BSTAR: begin
            if (c == CH_SLASH) p_mode = M_IDLE;
            else if (c != CH_STAR) p_mode = M_BLOCK;
            return 0;
         end
         M_DOT: begin
            p_mode = M_IDLE;
            if (c == CH_DOT) begin put(K_DOTDOT, p_begin, 16'd2, ln, E_NONE); return 0; end
            put(K_DOT, p_begin, 16'd1, ln, E_NONE);
            return 1;
         end
         M_EQ, M_LT, M_GT: begin
            two = (p_mode == M_EQ) ? K_EQ : (p_mode == M_LT) ? K_LTE : K_GTE;
            one = (p_mode == M_EQ) ? K_ASSIGN : (p_mode == M_LT) ? K_LT : K_GT;
            p_mode = M_IDLE;
            if (c == CH_EQ) begin put(two, p_begin, 16'd2, ln, E_NONE); return 0; end
            put(one, p_begin, 16'd1, ln, E_NONE);
            return 1;
         end
         M_BANG: begin
            p_mode = M_IDLE;
            if (c == CH_EQ) put(K_NEQ, p_begin, 16'd2, ln, E_NONE);
            else halt_with(p_begin, ln, E_BANG);
            return 0;
         end
         M_STR: begin
            if (c == CH_QUOTE) begin
               put(K_STRING, p_begin, gap(p_begin, off), ln, E_NONE);
               p_mode = M_IDLE;
            end else if (c == CH_BSLASH) p_mode = M_ESC;
            return 0;
         end
         M_ESC: begin
            p_mode = M_STR;
            return 0;
         end
         M_INT, M_FRAC: begin
            if (digit(c)) return 0;
            if (c == CH_DOT && p_mode == M_INT) begin
               p_dot = off;
               p_mode = M_NDOT;
               return 0;
            end
            p_mode = M_IDLE;
            if (c == CH_PERCENT) begin
               put(K_PERCENT, p_begin, gap(p_begin, off), ln, E_NONE);
               return 0;
            end
            if (c == CH_T) begin
               put(K_DURATION, p_begin, gap(p_begin, off), ln, E_NONE);
               return 0;
            end
            put(K_NUMBER, p_begin, gap(p_begin, off), ln, E_NONE);
            return 1;
         end
         M_NDOT: begin
            if (digit(c)) begin p_mode = M_FRAC; return 0; end
            put(K_NUMBER, p_begin, gap(p_begin, p_dot), ln, E_NONE);
            p_begin = p_dot;
            p_mode = M_DOT;
            return 1;
         end
         M_IDENT: begin
            if (letter(c) || digit(c)) return 0;
            put(K_IDENT, p_begin, gap(p_begin, off), ln, E_NONE);
            p_mode = M_IDLE;
            return 1;
         end
         default: begin
            p_mode = M_IDLE;
            return 1;
         end
      endcase
   endfunction

   // end of text: flush what is pending
   function automatic void lex_flush();
      case (p_mode)
         M_SLASH: put(K_SLASH, p_begin, 16'd1, p_line, E_NONE);
         M_BLOCK, M_BSTAR: halt_with(p_off, p_line, E_BLOCK);
         M_DOT: put(K_DOT, p_begin, 16'd1, p_line, E_NONE);
         M_EQ: put(K_ASSIGN, p_begin, 16'd1, p_line, E_NONE);
         M_LT: put(K_LT, p_begin, 16'd1, p_line, E_NONE);
         M_GT: put(K_GT, p_begin, 16'd1, p_line, E_NONE);
         M_BANG: halt_with(p_begin, p_line, E_BANG);
         M_STR: halt_with(p_begin, p_sline, E_STRING);
         M_ESC: halt_with(p_begin, p_sline, E_ESCAPE);
         M_INT, M_FRAC: put(K_NUMBER, p_begin, gap(p_begin, p_off), p_line, E_NONE);
         M_NDOT: begin
            put(K_NUMBER, p_begin, gap(p_begin, p_dot), p_line, E_NONE);
            put(K_DOT, p_dot, 16'd1, p_line, E_NONE);
         end
         M_IDENT: put(K_IDENT, p_begin, gap(p_begin, p_off), p_line, E_NONE);
         default: ;
      endcase
      if (!p_halt) put(K_EOF, p_off, 16'd0, p_line, E_NONE);
   endfunction

   function automatic void lex_item(logic [7:0] c, logic eot);
      int n;
      burst.delete();
      if (eot || c == CH_NUL) begin
         if (!p_halt) lex_flush();
         text_restart();
      end else begin
         p_intext = 1;
         if (!p_halt) begin
            for (n = 0; n < 3 && !p_halt; n++)
               if (!lex_byte(c)) break;
            if (p_off < OFF_CAP) p_off++;
            if (c == CH_NL && p_line != LINE_CAP) p_line++;
         end
      end
      if (burst.size() > 0) burst[burst.size() - 1].last = 1;
      foreach (burst[i]) tokens_due.push_back(burst[i]);
   endfunction

   // ---------------- checking ----------------
   task automatic report(string what);
      fails++;
      $display("MISMATCH @%0d: %s", cycles, what);
   endtask

   always @(posedge clock) begin
      token_type e;
      cycles++;
      req_acc = req_valid && !req_stall;
      if (req_acc) lex_item(req_ch, req_end_of_text);
      if (csr_valid && csr_ready) begin
         p_first = csr_data;
         if (!p_intext) p_line = csr_data;
      end
      if (rsp_valid && !rsp_stall) begin
         if (tokens_due.size() == 0) begin
            report($sformatf("token kind %0d with nothing expected", rsp_token_kind));
         end else begin
            e = tokens_due.pop_front();
            if (rsp_token_kind !== e.kind)
               report($sformatf("kind %0d, want %0d", rsp_token_kind, e.kind));
            if (rsp_token_start !== e.start)
               report($sformatf("start %0d, want %0d", rsp_token_start, e.start));
            if (rsp_token_len !== e.len)
               report($sformatf("len %0d, want %0d", rsp_token_len, e.len));
            if (rsp_token_line !== e.line)
               report($sformatf("line %0d, want %0d", rsp_token_line, e.line));
            if (rsp_error_code !== e.err)
               report($sformatf("error %0d, want %0d", rsp_error_code, e.err));
            if (rsp_last !== e.last)
               report($sformatf("last %0d, want %0d", rsp_last, e.last));
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > LIMIT) begin
         $display("dsl_token_lexer_top verification failed");
         $finish;
      end
   end

   // ---------------- driving ----------------
   always @(negedge clock) begin
      byte_item_type b;
      if (!reset) begin
         if (!req_valid || req_acc) begin
            if (src_bytes.size() > 0 && $urandom_range(99) >= idle_pct) begin
               b = src_bytes.pop_front();
               req_ch <= b.ch;
               req_end_of_text <= b.eot;
               req_valid <= 1;
            end else begin
               req_valid <= 0;
            end
         end
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   // ---------------- stimulus ----------------
   task automatic put_byte(logic [7:0] c);
      src_bytes.push_back('{c, 1'b0});
      pushed++;
   endtask

   task automatic put_str(string s);
      foreach (s[i]) put_byte(s[i]);
   endtask

   task automatic end_text();
      if ($urandom_range(1)) src_bytes.push_back('{8'(($urandom_range(255))), 1'b1});
      else src_bytes.push_back('{CH_NUL, 1'b0});
      pushed++;
   endtask

   task automatic settle();
      while (src_bytes.size() > 0 || req_valid || tokens_due.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_first_line(logic [15:0] v);
      @(negedge clock);
      csr_valid <= 1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // body byte of a string or comment: any nonzero byte except the terminator
   function automatic logic [7:0] body_byte(logic [7:0] stop);
      logic [7:0] c;
      do c = 8'($urandom_range(255, 1)); while (c == stop);
      return c;
   endfunction

   task automatic put_token();
      string puncts, ops[10];
      int n;
      puncts = "{}()[]:;,+-*/";
      ops = '{"=", "==", "!=", "<", "<=", ">", ">=", ".", "..", "!"};
      case ($urandom_range(9))
         0: put_byte(puncts[$urandom_range(puncts.len() - 1)]);
         1: put_str(ops[$urandom_range(($urandom_range(9) == 0) ? 9 : 8)]);
         2: begin
            put_byte(CH_QUOTE);
            repeat ($urandom_range(5)) begin
               if ($urandom_range(4) == 0) begin
                  put_byte(CH_BSLASH);
                  put_byte(8'($urandom_range(255, 1)));
               end else begin
                  put_byte(body_byte(CH_QUOTE) == CH_BSLASH ? "x" : body_byte(CH_QUOTE));
               end
            end
            if ($urandom_range(9) != 0) put_byte(CH_QUOTE);
         end
         3, 4: begin
            repeat ($urandom_range(3, 1)) put_byte(8'($urandom_range("9", "0")));
            n = $urandom_range(3);
            if (n >= 1) put_byte(CH_DOT);
            if (n >= 2) repeat ($urandom_range(2, 1)) put_byte(8'($urandom_range("9", "0")));
            case ($urandom_range(3))
               0: put_byte(CH_PERCENT);
               1: put_byte(CH_T);
               default: ;
            endcase
         end
         5: begin
            put_byte(8'($urandom_range("z", "a")));
            repeat ($urandom_range(4)) put_byte($urandom_range(1) ? "_" : "Q");
            if ($urandom_range(1)) put_byte(8'($urandom_range("9", "0")));
         end
         6: put_byte($urandom_range(1) ? 8'h20 : 8'($urandom_range(13, 9)));
         7: begin
            n = $urandom_range(2);
            if (n == 0) put_byte(CH_HASH);
            else if (n == 1) put_str("//");
            if (n < 2) begin
               repeat ($urandom_range(4)) put_byte(body_byte(CH_NL));
               put_byte(CH_NL);
            end else begin
               put_str("/*");
               repeat ($urandom_range(5)) put_byte(body_byte(CH_SLASH));
               if ($urandom_range(7) != 0) put_str("*/");
            end
         end
         8: put_byte(8'(CH_NL));
         default: put_byte(8'($urandom_range(255, 1)));
      endcase
   endtask

   task automatic random_texts(int goal);
      int stop_at;
      stop_at = pushed + goal;
      while (pushed < stop_at) begin
         repeat ($urandom_range(12, 1)) begin
            put_token();
            if ($urandom_range(2) == 0) put_byte(8'h20);
         end
         end_text();
      end
   endtask

   initial begin
      p_first = FIRST_LINE_RESET;
      text_restart();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: every kind, pairs, suffixes, errors; each text ends in a randomly chosen end form
      put_str("{}()[]:;,+-*/=<>");
      end_text();
      put_str("..==!=<=>=7.x");
      end_text();
      put_str("\"a\\\"\"1.5%2t");
      end_text();
      put_str("a_9#c\n/**/!");
      end_text();
      put_byte(8'hFF);
      end_text();
      put_str("\"\\");
      end_text();
      put_str("/*");
      end_text();
      settle();

      write_first_line(16'd0);
      random_texts(110);
      settle();

      // line count saturation near the top
      write_first_line(16'hFFFD);
      put_str("x\n\n\n\n#");
      repeat (20) put_byte(body_byte(CH_NL));
      put_str("\nab 3");
      end_text();
      settle();

      write_first_line(16'hFFFF);
      idle_pct = 0;
      random_texts(110);
      settle();

      idle_pct = 30;
      write_first_line(16'($urandom_range(65535)));
      random_texts(120);
      settle();

      if (fails == 0) $display("dsl_token_lexer_top verification clean");
      else $display("dsl_token_lexer_top verification failed");
      $finish;
   end
endmodule
